>>> rtl/lcg48_pkg.sv
// ----------------------------------------------------------------------------
// lcg48_pkg: shared types and constants for the bounded random unit
// Holds item structs, generator constants and controller/datapath links.
// ----------------------------------------------------------------------------
package lcg48_pkg;

  localparam int SeedW = 48;
  localparam int IntBits = 31;
  localparam int FracBits = 24;
  localparam logic [SeedW-1:0] LcgMult = 48'h0005_DEEC_E66D;
  localparam logic [SeedW-1:0] LcgInc = 48'h0000_0000_000B;

  typedef enum logic [1:0] {
    CMD_SEED  = 2'd0,
    CMD_BOUND = 2'd1,
    CMD_FRAC  = 2'd2,
    CMD_RANGE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] seed_value;
    logic signed [31:0] bound;
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               error;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item, compute bound
    logic seed;      // load seed from item
    logic mul_lo;    // first multiply partial product
    logic mul_hi;    // second partial product, advance seed
    logic scale;     // power-of-two result
    logic div_start; // start the remainder
    logic div_step;  // one remainder bit
    logic finish;    // form result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       neg;
    logic       pow2;
    logic       div_last;
    logic       accept;
  } dp_stat_t;

endpackage

>>> rtl/lcg48_ctrl.sv
// ----------------------------------------------------------------------------
// lcg48_ctrl: command sequencer
// Loads seeds; walks each draw through seed advance, then scaling or remainder with redraws.
// ----------------------------------------------------------------------------
module lcg48_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  lcg48_pkg::dp_stat_t stat,
  output lcg48_pkg::dp_cmd_t  cmd,
  output logic                busy,
  output logic                done
);
  import lcg48_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_MUL_LO, S_MUL_HI, S_POST, S_DIV, S_CHECK, S_DONE
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    cmd.load = start;
    case (state)
      S_DECODE: cmd.seed = (stat.cmd == CMD_SEED);
      S_MUL_LO: cmd.mul_lo = 1'b1;
      S_MUL_HI: cmd.mul_hi = 1'b1;
      S_POST: begin
        cmd.scale = stat.pow2;
        cmd.div_start = (stat.cmd != CMD_FRAC) && !stat.pow2;
      end
      S_DIV: cmd.div_step = 1'b1;
      S_DONE: cmd.finish = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (start) state <= S_DECODE;
        S_DECODE: begin
          // a negative bound only matters for the bounded and range draws
          if (stat.cmd == CMD_SEED || (stat.neg && stat.cmd != CMD_FRAC)) state <= S_DONE;
          else state <= S_MUL_LO;
        end
        S_MUL_LO: state <= S_MUL_HI;
        S_MUL_HI: state <= S_POST;
        S_POST: begin
          if (stat.cmd == CMD_FRAC || stat.pow2) state <= S_DONE;
          else state <= S_DIV;
        end
        S_DIV: if (stat.div_last) state <= S_CHECK;
        S_CHECK: state <= stat.accept ? S_DONE : S_MUL_LO;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_from_known: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DECODE) || $past(state == S_POST) || $past(state == S_CHECK))
    else $error("done from unexpected state");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("start while busy");
  a_div_leads_check: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && stat.div_last) |=> state == S_CHECK)
    else $error("remainder did not end in check");
endmodule

>>> rtl/lcg48_dpath.sv
// ----------------------------------------------------------------------------
// lcg48_dpath: seed register, split multiplier and restoring remainder
// ----------------------------------------------------------------------------
module lcg48_dpath (
  input  logic                clk,
  input  logic                rst,
  input  lcg48_pkg::in_item_t in_item,
  input  lcg48_pkg::dp_cmd_t  cmd,
  output lcg48_pkg::dp_stat_t stat,
  output lcg48_pkg::out_item_t result
);
  import lcg48_pkg::*;

  logic [SeedW-1:0] lcg_seed;
  logic [1:0]       op;
  logic [31:0]      n;
  logic [31:0]      mn;
  logic [31:0]      sv;
  logic [SeedW-1:0] prod_lo;
  logic [30:0]      r;
  logic [31:0]      rem;
  logic [30:0]      quo_src;
  logic [4:0]       bit_cnt;
  logic [31:0]      v;

  logic [31:0] n_next;
  logic [SeedW-1:0] seed_next;
  logic [32:0] rem_shift;
  logic [32:0] rem_sub;
  logic [62:0] scaled;
  logic [32:0] acc_sum;

  always_comb begin
    n_next = (in_item.cmd == CMD_RANGE) ? 32'(in_item.range_max - in_item.range_min)
                                        : in_item.bound;
  end

  // seed * mult mod 2^48: low 24 bits of seed times mult, then high 24 bits
  assign seed_next = prod_lo + (SeedW'(lcg_seed[47:24] * LcgMult[23:0]) << 24) + LcgInc;
  assign rem_shift = {rem, quo_src[30]};
  assign rem_sub = rem_shift - {1'b0, n};
  assign scaled = 63'(n) * 63'(r);
  assign acc_sum = 33'({1'b0, r}) - 33'(v) + 33'(n) - 33'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_seed <= LcgMult;
    end else begin
      if (cmd.load) begin
        op <= in_item.cmd;
        n <= n_next;
        mn <= in_item.range_min;
        sv <= in_item.seed_value;
      end
      if (cmd.seed) lcg_seed <= {{16{sv[31]}}, sv} ^ LcgMult;
      if (cmd.mul_lo) prod_lo <= SeedW'(lcg_seed[23:0] * LcgMult);
      if (cmd.mul_hi) begin
        lcg_seed <= seed_next;
        r <= seed_next[47:17];
      end
      if (cmd.scale) v <= 32'(scaled >> IntBits);
      if (cmd.div_start) begin
        rem <= '0;
        quo_src <= r;
        bit_cnt <= '0;
      end
      if (cmd.div_step) begin
        rem <= rem_sub[32] ? rem_shift[31:0] : rem_sub[31:0];
        quo_src <= {quo_src[29:0], 1'b0};
        bit_cnt <= bit_cnt + 5'd1;
        if (bit_cnt == 5'd30) v <= rem_sub[32] ? rem_shift[31:0] : rem_sub[31:0];
      end
      if (cmd.finish) begin
        result.error <= (op != CMD_SEED && op != CMD_FRAC) && n[31];
        case (op)
          CMD_SEED: result.value <= '0;
          CMD_FRAC: result.value <= 32'(lcg_seed[47:24]);
          CMD_BOUND: result.value <= n[31] ? 32'd0 : v;
          CMD_RANGE: result.value <= n[31] ? 32'd0 : mn + v;
          default: result.value <= '0;
        endcase
      end
    end
  end

  assign stat.cmd = op;
  assign stat.neg = n[31];
  assign stat.pow2 = ((n & (32'd0 - n)) == n);
  assign stat.div_last = (bit_cnt == 5'd30);
  assign stat.accept = !acc_sum[31] && !acc_sum[32];
endmodule

>>> rtl/lcg48_bounded_random_unit.sv
// ----------------------------------------------------------------------------
// lcg48_bounded_random_unit: 48-bit LCG with bounded, fraction and range draws
// Top level: handshake, sequencer and datapath.
// ----------------------------------------------------------------------------
// channel | dir | payload            | handshake
// in      | in  | in_item_t          | in_valid / in_ready
// out     | out | out_item_t         | out_valid / out_ready
//
// Seed and error items pass from decode straight to done; fraction and
// power-of-two draws go through both multiply states and post. Other bounds
// add the 31-step remainder, the long pole, and a check; each rejected draw repeats the multiply, remainder and check.
// Reset loads the seed as if seeded with zero.
// A finished item waiting in the output register holds off new input until
// the receiver takes it.
// ----------------------------------------------------------------------------
module lcg48_bounded_random_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lcg48_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lcg48_pkg::out_item_t out_data
);
  import lcg48_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_item_t result;
  logic      busy;
  logic      done;
  logic      start;

  // hold new work while busy, or while a finished item still waits unless it leaves now
  assign in_ready = !busy && (!out_valid || out_ready);
  assign start = in_valid && in_ready;

  lcg48_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat),
    .cmd(cmd), .busy(busy), .done(done)
  );

  lcg48_dpath u_dpath (
    .clk(clk), .rst(rst), .in_item(in_data), .cmd(cmd),
    .stat(stat), .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (done) out_valid <= 1'b1;
    end
  end

  assign out_data = result;

  a_done_slot: assert property (@(posedge clk) disable iff (rst)
    done |-> !out_valid || out_ready) else $error("result overwrote waiting item");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error) |-> out_data.value == 32'd0)
    else $error("error item with nonzero value");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("ready while busy");
endmodule

>>> dv/lcg48_checker.sv
// ----------------------------------------------------------------------------
// lcg48_checker: scoreboard for the bounded random unit
// Watches both channels, predicts each result from a private seed copy and
// compares value and error of every result against the oldest prediction.
// ----------------------------------------------------------------------------
module lcg48_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  lcg48_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  lcg48_pkg::out_item_t out_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcg48_pkg::*;

  logic [47:0] gen_seed;
  out_item_t   expected_q[$];

  assign pending = expected_q.size();

  function automatic logic [47:0] step_seed(input logic [47:0] s);
    logic [95:0] prod;
    prod = s * LcgMult + LcgInc;
    return prod[47:0];
  endfunction

  // Draw below n; a negative pattern is an error and leaves the seed alone.
  task automatic draw_below(input logic [31:0] n, output logic [31:0] v,
                            output logic err);
    logic [63:0] r;
    logic [63:0] m;
    err = 1'b0;
    v = '0;
    if (n[31]) begin
      err = 1'b1;
    end else if ((n & (32'd0 - n)) == n) begin
      gen_seed = step_seed(gen_seed);
      r = {33'd0, gen_seed[47:17]};
      m = ({32'd0, n} * r) >> 31;
      v = m[31:0];
    end else begin
      forever begin
        gen_seed = step_seed(gen_seed);
        r = {33'd0, gen_seed[47:17]};
        m = r % {32'd0, n};
        if (r - m + ({32'd0, n} - 64'd1) <= 64'h7FFF_FFFF) begin
          v = m[31:0];
          break;
        end
      end
    end
  endtask

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    in_item_t    it;
    out_item_t   exp_item;
    logic [31:0] v;
    logic        e;
    if (rst) begin
      gen_seed <= LcgMult;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected item", out_data.value, 32'd0);
        end else begin
          exp_item = expected_q.pop_front();
          if (out_data.value !== exp_item.value)
            report("value", out_data.value, exp_item.value);
          if (out_data.error !== exp_item.error)
            report("error", {31'd0, out_data.error}, {31'd0, exp_item.error});
        end
      end
      if (in_valid && in_ready) begin
        it = in_data;
        v = '0;
        e = 1'b0;
        case (cmd_t'(it.cmd))
          CMD_SEED: gen_seed = {{16{it.seed_value[31]}}, it.seed_value} ^ LcgMult;
          CMD_BOUND: draw_below(it.bound, v, e);
          CMD_FRAC: begin
            gen_seed = step_seed(gen_seed);
            v = {8'd0, gen_seed[47:24]};
          end
          default: begin
            draw_below(it.range_max - it.range_min, v, e);
            if (!e) v = it.range_min + v;
          end
        endcase
        exp_item.value = v;
        exp_item.error = e;
        expected_q.push_back(exp_item);
      end
    end
  end
endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the bounded random unit
// Directed corner items, then random command mixes with random idling on
// both sides, a long output hold-off and a drain pause; the checker scores.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lcg48_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  bit        hold_off_req = 1'b0;

  always #6 clk = ~clk;

  lcg48_bounded_random_unit DUT (.*);

  lcg48_checker u_checker (.*);

  // Offer one item: hold valid and payload until the handshake.
  task automatic offer(input cmd_t c, input logic [31:0] sv, input logic [31:0] b,
                       input logic [31:0] mn, input logic [31:0] mx);
    in_item_t it;
    it.cmd = c;
    it.seed_value = sv;
    it.bound = b;
    it.range_min = mn;
    it.range_max = mx;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Idle a random number of cycles after an accepted item.
  task automatic gap(input bit idle_on);
    int n;
    n = idle_on ? $urandom_range(0, 9) : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random bound: half small, the rest powers of two, random patterns and values near 2^31 and 2^30.
  function automatic logic [31:0] pick_bound();
    case ($urandom_range(0, 7))
      0: return 32'd1 << $urandom_range(0, 30);
      1: return $urandom;
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      3: return 32'h4000_0001 + $urandom_range(0, 1000);
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  function automatic logic [31:0] small_span();
    return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
  endfunction

  task automatic random_item(input bit idle_on);
    logic [31:0] mn;
    logic [31:0] mx;
    mn = $urandom;
    mx = mn + small_span();
    if ($urandom_range(0, 5) == 0) mx = $urandom;
    offer(cmd_t'($urandom_range(0, 3)), $urandom, pick_bound(), mn, mx);
    gap(idle_on);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int n;
    wait (!rst);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off_req = 1'b0;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset seed draws, seeding extremes, every command and corner.
    offer(CMD_FRAC, 0, 0, 0, 0);
    offer(CMD_BOUND, 0, 32'd10, 0, 0);
    offer(CMD_SEED, 32'h8000_0000, 0, 0, 0);
    offer(CMD_FRAC, 0, 0, 0, 0);
    offer(CMD_SEED, 32'h7FFF_FFFF, 0, 0, 0);
    offer(CMD_BOUND, 0, 32'd0, 0, 0);
    offer(CMD_BOUND, 0, 32'd1, 0, 0);
    offer(CMD_BOUND, 0, 32'h4000_0000, 0, 0);
    offer(CMD_BOUND, 0, 32'h7FFF_FFFF, 0, 0);
    offer(CMD_BOUND, 0, 32'h4000_0001, 0, 0);
    offer(CMD_BOUND, 0, 32'h8000_0000, 0, 0);
    offer(CMD_BOUND, 0, 32'hFFFF_FFFF, 0, 0);
    offer(CMD_SEED, 32'hFFFF_FFFF, 0, 0, 0);
    offer(CMD_BOUND, 0, 32'd3, 0, 0);
    offer(CMD_RANGE, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    offer(CMD_RANGE, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    offer(CMD_RANGE, 0, 0, 32'h7FFF_FFF0, 32'h7FFF_FFFF);
    offer(CMD_RANGE, 0, 0, 32'd5, 32'd5);
    offer(CMD_RANGE, 0, 0, 32'd5, 32'd3);
    offer(CMD_RANGE, 0, 0, 32'h8000_0000, 32'h8000_0010);
    offer(CMD_FRAC, 0, 0, 0, 0);
    offer(CMD_SEED, 0, 0, 0, 0);
    offer(CMD_BOUND, 0, 32'h5555_5555, 0, 0);
    offer(CMD_BOUND, 0, 32'hAAAA_AAAA, 0, 0);
    gap(1'b1);

    for (int i = 0; i < 1350; i++) begin
      if (i == 300) hold_off_req = 1'b1;
      if (i == 700) begin
        // Drain: hold the input until every result is back.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      random_item(!(i >= 900 && i < 1000));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

>>> filelist.f
rtl/lcg48_pkg.sv
rtl/lcg48_ctrl.sv
rtl/lcg48_dpath.sv
rtl/lcg48_bounded_random_unit.sv
dv/lcg48_checker.sv
dv/tb_top.sv
